FILE: hw/rtl/lstp_pkg.sv
// Shared types and constants of the least-scheduled task picker.
package lstp_pkg;

  localparam int unsigned TASK_W = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned WCNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SWAP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [TASK_W-1:0] running_task;
    logic              switched;
    logic              no_runnable;
    logic              add_rejected;
    logic [WCNT_W-1:0] waiting_count;
  } res_t;

endpackage

FILE: hw/rtl/lstp_if.sv
// Valid/ready channel interfaces for task commands and scheduling results.
interface lstp_in_if import lstp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TASK_W-1:0] new_task;

  modport source (output valid, output operation, output new_task, input ready);
  modport sink   (input valid, input operation, input new_task, output ready);
endinterface

interface lstp_out_if import lstp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] running_task;
  logic              switched;
  logic              no_runnable;
  logic              add_rejected;
  logic [WCNT_W-1:0] waiting_count;

  modport source (output valid, output running_task, output switched, output no_runnable,
                  output add_rejected, output waiting_count, input ready);
  modport sink   (input valid, input running_task, input switched, input no_runnable,
                  input add_rejected, input waiting_count, output ready);
endinterface

FILE: hw/rtl/lstp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lstp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lstp_ctrl.sv
// Sequencer: add, compaction and least-count scan over the slot RAM, task swap.
module lstp_ctrl import lstp_pkg::*; #(
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned COUNT_BITS = 32,
  localparam int unsigned AW = $clog2(MAX_TASKS),
  localparam int unsigned EW = TASK_W + 1 + COUNT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [TASK_W-1:0] in_task_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [EW-1:0]     mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [EW-1:0]     mem_rdata_i
);

  localparam int unsigned FW = $clog2(MAX_TASKS + 1);

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [TASK_W-1:0]     nt_q, nt_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [FW-1:0]         rd_q, rd_d;
  logic [FW-1:0]         wr_q, wr_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         pidx_q, pidx_d;
  logic                  best_vld_q, best_vld_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic [TASK_W-1:0]     best_id_q, best_id_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic [TASK_W-1:0]     cur_id_q, cur_id_d;
  logic [COUNT_BITS-1:0] cur_cnt_q, cur_cnt_d;
  logic                  sw_q, sw_d;
  logic                  none_q, none_d;
  logic                  rej_q, rej_d;

  logic                  compact;
  logic                  rd_en;
  logic [TASK_W-1:0]     r_task;
  logic                  r_fin;
  logic [COUNT_BITS-1:0] r_cnt;
  logic                  take;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign compact = (op_q == OP_TICK);
  assign rd_en   = (state_q == ST_SCAN) && (rd_q < fill_q);
  assign r_task  = mem_rdata_i[EW-1 -: TASK_W];
  assign r_fin   = mem_rdata_i[COUNT_BITS];
  assign r_cnt   = mem_rdata_i[COUNT_BITS-1:0];
  assign take    = !r_fin && (!best_vld_q || (best_cnt_q > r_cnt));
  assign cnt_inc = (best_cnt_q == {COUNT_BITS{1'b1}}) ? best_cnt_q
                                                      : best_cnt_q + COUNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      cur_id_q   <= '0;
      cur_cnt_q  <= '0;
      pend_q     <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      cur_id_q   <= cur_id_d;
      cur_cnt_q  <= cur_cnt_d;
      pend_q     <= pend_d;
      best_vld_q <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    nt_q       <= nt_d;
    rd_q       <= rd_d;
    wr_q       <= wr_d;
    pidx_q     <= pidx_d;
    best_idx_q <= best_idx_d;
    best_id_q  <= best_id_d;
    best_cnt_q <= best_cnt_d;
    sw_q       <= sw_d;
    none_q     <= none_d;
    rej_q      <= rej_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    nt_d        = nt_q;
    fill_d      = fill_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pend_d      = 1'b0;
    pidx_d      = rd_q[AW-1:0];
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_id_d   = best_id_q;
    best_cnt_d  = best_cnt_q;
    cur_id_d    = cur_id_q;
    cur_cnt_d   = cur_cnt_q;
    sw_d        = sw_q;
    none_d      = none_q;
    rej_d       = rej_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = {nt_q, 1'b0, {COUNT_BITS{1'b0}}};
    mem_re_o    = rd_en;
    mem_raddr_o = rd_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_op_i;
          nt_d       = in_task_i;
          rd_d       = '0;
          wr_d       = '0;
          best_vld_d = 1'b0;
          sw_d       = 1'b0;
          none_d     = 1'b0;
          rej_d      = 1'b0;
          case (in_op_i)
            OP_ADD:  state_d = ST_ADD;
            OP_TICK: state_d = ST_SCAN;
            OP_END:  state_d = ST_SCAN;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_ADD: begin
        if (fill_q == FW'(MAX_TASKS)) begin
          rej_d = 1'b1;
        end else begin
          mem_we_o = 1'b1;
          fill_d   = fill_q + FW'(1);
        end
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_d   = rd_q + FW'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (compact && !r_fin) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = wr_q[AW-1:0];
            mem_wdata_o = mem_rdata_i;
            wr_d        = wr_q + FW'(1);
          end
          if (take) begin
            best_vld_d = 1'b1;
            best_idx_d = compact ? wr_q[AW-1:0] : pidx_q;
            best_id_d  = r_task;
            best_cnt_d = r_cnt;
          end
        end
        if (!rd_en && !pend_q) begin
          if (compact) begin
            fill_d = wr_q;
          end
          state_d = ST_SWAP;
        end
      end
      ST_SWAP: begin
        if (best_vld_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = best_idx_q;
          mem_wdata_o = {cur_id_q, (op_q == OP_END), cur_cnt_q};
          cur_id_d    = best_id_q;
          cur_cnt_d   = cnt_inc;
          sw_d        = 1'b1;
        end else begin
          none_d = 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = '{running_task:  cur_id_q,
                   switched:      sw_q,
                   no_runnable:   none_q,
                   add_rejected:  rej_q,
                   waiting_count: WCNT_W'(fill_q)};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_TASKS))
    else $error("fill level beyond table depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("slot written and read in the same cycle");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pend_q) |-> (wr_q <= FW'(pidx_q)))
    else $error("compaction write ran ahead of the read");

  a_pick_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP && best_vld_q) |-> (FW'(best_idx_q) < fill_q))
    else $error("chosen slot outside occupied table");

  a_swap_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP) |=> (sw_q != none_q))
    else $error("swap result flags inconsistent");

endmodule

FILE: hw/rtl/least_scheduled_task_picker.sv
// Least-scheduled task picker: command channel in, one result per command out.
//
// Usage: task_i carries commands (operation, new_task); result_o returns one
// result for each command (running task, switched, no_runnable, add_rejected,
// waiting_count). Both channels transfer on valid and ready high at a clock edge.
// Commands are handled one at a time. An add passes the add state, then the result
// state, then the output register; tick and end first make one pass of the slot RAM
// read port over the occupied slots (tick compacts in that pass), then pass the
// swap state, the result state and the output register.
// An unused operation code goes straight to the result state with the state unchanged.
// The next command is accepted in the cycle after the previous result enters the
// output register.
// A finished result waits in an output register, so the next command is
// accepted while result_o is stalled; it finishes its work and then holds until
// the register frees.
// Reset (asynchronous, active low) empties the table and makes task 0 the
// running task with a zero count; no clearing pass is needed.
module least_scheduled_task_picker import lstp_pkg::*; #(
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lstp_in_if.sink     task_i,
  lstp_out_if.source  result_o
);

  localparam int unsigned AW = $clog2(MAX_TASKS);
  localparam int unsigned EW = TASK_W + 1 + COUNT_BITS;

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  logic          out_valid_q;
  res_t          out_q;

  lstp_ctrl #(
    .MAX_TASKS  (MAX_TASKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (task_i.valid),
    .in_ready_o  (task_i.ready),
    .in_op_i     (task_i.operation),
    .in_task_i   (task_i.new_task),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lstp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.running_task  = out_q.running_task;
  assign result_o.switched      = out_q.switched;
  assign result_o.no_runnable   = out_q.no_runnable;
  assign result_o.add_rejected  = out_q.add_rejected;
  assign result_o.waiting_count = out_q.waiting_count;

endmodule
